// ----- hw/rtl/sequential_list_engine_assert.svh -----
// assertion macros used by the list engine top level
`ifndef SEQUENTIAL_LIST_ENGINE_ASSERT_SVH
`define SEQUENTIAL_LIST_ENGINE_ASSERT_SVH

// same-cycle implication
`define SLE_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sle check failed: same-cycle implication");

// next-cycle implication
`define SLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sle check failed: next-cycle implication");

`endif

// ----- hw/rtl/sle_pkg.sv -----
// shared constants, types and codes of the list engine
package sle_pkg;

	localparam int CAPACITY    = 512;
	localparam int WORD_BITS   = 32;
	localparam int OP_BITS     = 3;
	localparam int POS_BITS    = 10;
	localparam int STATUS_BITS = 2;
	localparam int COUNT_BITS  = 10;

	// internal count holds 0..CAPACITY
	localparam int CNT_BITS   = $clog2(CAPACITY + 1);
	localparam int CMP_BITS   = (POS_BITS > CNT_BITS) ? POS_BITS : CNT_BITS;
	localparam int GROUP_SIZE = 16;
	localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

	typedef logic [WORD_BITS-1:0]   word_t;
	typedef logic [CMP_BITS-1:0]    slot_pos_t;
	typedef logic [CNT_BITS-1:0]    cnt_t;
	typedef logic [OP_BITS-1:0]     op_t;
	typedef logic [STATUS_BITS-1:0] status_t;

	localparam op_t OP_INS_HEAD = OP_BITS'(0);
	localparam op_t OP_INS_TAIL = OP_BITS'(1);
	localparam op_t OP_INS_AT   = OP_BITS'(2);
	localparam op_t OP_REM_HEAD = OP_BITS'(3);
	localparam op_t OP_REM_TAIL = OP_BITS'(4);
	localparam op_t OP_REM_AT   = OP_BITS'(5);

	localparam status_t ST_OK    = STATUS_BITS'(0);
	localparam status_t ST_FULL  = STATUS_BITS'(1);
	localparam status_t ST_EMPTY = STATUS_BITS'(2);
	localparam status_t ST_RANGE = STATUS_BITS'(3);

	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_INS,
		CMD_REM
	} cmd_kind_t;

	// broadcast to every slot cell
	typedef struct packed {
		cmd_kind_t kind;
		slot_pos_t pos;
		word_t     value;
	} cell_cmd_t;

endpackage

// ----- hw/rtl/sle_req_if.sv -----
// request channel: operation beats into the list engine
interface sle_req_if;
	import sle_pkg::*;

	logic                    valid;
	logic                    ready;
	op_t                     op;
	logic [POS_BITS-1:0]     position;
	word_t                   value;

	modport source (output valid, op, position, value, input ready);
	modport sink   (input valid, op, position, value, output ready);
endinterface

// ----- hw/rtl/sle_rsp_if.sv -----
// response channel: result beats out of the list engine
interface sle_rsp_if;
	import sle_pkg::*;

	logic                  valid;
	logic                  ready;
	word_t                 removed_word;
	status_t               status;
	logic [COUNT_BITS-1:0] entry_count;

	modport source (output valid, removed_word, status, entry_count, input ready);
	modport sink   (input valid, removed_word, status, entry_count, output ready);
endinterface

// ----- hw/rtl/sle_cell.sv -----
// one list slot: holds a word, shifts with its neighbors, taps out on removal
module sle_cell (
	input  logic              clk,
	input  sle_pkg::cell_cmd_t cmd,
	input  sle_pkg::slot_pos_t index,
	input  sle_pkg::word_t    left_word,
	input  sle_pkg::word_t    right_word,
	output sle_pkg::word_t    word,
	output sle_pkg::word_t    tap
);
	import sle_pkg::*;

	word_t word_q;
	word_t tap_q;
	logic  hit;
	logic  above;

	assign hit   = (index == cmd.pos);
	assign above = (index > cmd.pos);

	always_ff @(posedge clk) begin
		case (cmd.kind)
			CMD_INS: begin
				if (hit) begin
					word_q <= cmd.value;
				end else if (above) begin
					word_q <= left_word;
				end
			end
			CMD_REM: begin
				if (hit || above) begin
					word_q <= right_word;
				end
			end
			default: begin
				word_q <= word_q;
			end
		endcase
		tap_q <= (cmd.kind == CMD_REM && hit) ? word_q : '0;
	end

	assign word = word_q;
	assign tap  = tap_q;
endmodule

// ----- hw/rtl/sle_group.sv -----
// first level of the removed-word gather: or of one group of cell taps
module sle_group (
	input  logic           clk,
	input  logic           load,
	input  sle_pkg::word_t taps [sle_pkg::GROUP_SIZE],
	output sle_pkg::word_t acc
);
	import sle_pkg::*;

	word_t acc_s2;
	word_t acc_d;

	always_comb begin
		acc_d = '0;
		for (int i = 0; i < GROUP_SIZE; i++) begin
			acc_d = acc_d | taps[i];
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			acc_s2 <= acc_d;
		end
	end

	assign acc = acc_s2;
endmodule

// ----- hw/rtl/sequential_list_engine.sv -----
// top level of the list engine: decode, slot cell row, gather tree, result register
`include "sequential_list_engine_assert.svh"

// Ordered list of up to CAPACITY words kept in a row of slot cells, slot 0 being
// the head. Each request beat asks for insert head/tail/at or remove head/tail/at
// and yields exactly one response beat with the removed word (zero unless a
// removal succeeds), a status (ok, full, empty, out of range) and the new count.
// A failed operation leaves the list untouched; unused op codes answer ok with
// the count unchanged. The decode against the count and the shift of every cell
// happen at the accepting edge, so the list itself changes at that edge. The
// removed word is then gathered by a registered or-tree (groups of 16 cells,
// then the group results) through the cell tap, group and output registers;
// a new request is taken only once the last one is in the output register.
// A result left waiting in the output register does not block the next
// request, only the following gather stage.
// Slots need no clearing after reset: only slots below the count are ever read.
module sequential_list_engine (
	input  logic clk,
	input  logic arst_n,
	sle_req_if.sink   req,
	sle_rsp_if.source rsp
);
	import sle_pkg::*;

	// list length and the one item in flight
	cnt_t      count_q;
	logic      v_s1;
	logic      v_s2;
	status_t   st_s1;
	status_t   st_s2;
	cnt_t      cnt_s1;
	cnt_t      cnt_s2;

	// output register
	logic      rsp_valid_q;
	word_t     removed_q;
	status_t   status_q;
	cnt_t      entry_count_q;

	logic      req_fire;
	logic      out_free;
	logic      out_load;

	// decode
	cell_cmd_t cmd;
	status_t   st_dec;
	logic      is_ins;
	logic      is_rem;
	slot_pos_t tgt_pos;
	slot_pos_t cnt_ext;
	logic      full;
	logic      empty;

	// cell row and gather tree
	word_t     cell_word [CAPACITY];
	word_t     taps_all  [NUM_GROUPS][GROUP_SIZE];
	word_t     grp_acc   [NUM_GROUPS];
	word_t     gather;

	assign req.ready = !v_s1 && !v_s2;
	assign req_fire  = req.valid && req.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign out_load  = v_s2 && out_free;

	assign cnt_ext = CMP_BITS'(count_q);
	assign full    = (count_q == CNT_BITS'(CAPACITY));
	assign empty   = (count_q == '0);

	// op decode: which kind of shift and at which slot
	always_comb begin
		is_ins  = 1'b0;
		is_rem  = 1'b0;
		tgt_pos = '0;
		unique case (req.op)
			OP_INS_HEAD: begin
				is_ins = 1'b1;
			end
			OP_INS_TAIL: begin
				is_ins  = 1'b1;
				tgt_pos = cnt_ext;
			end
			OP_INS_AT: begin
				is_ins  = 1'b1;
				tgt_pos = CMP_BITS'(req.position);
			end
			OP_REM_HEAD: begin
				is_rem = 1'b1;
			end
			OP_REM_TAIL: begin
				is_rem  = 1'b1;
				// empty list is caught below before this slot matters
				tgt_pos = cnt_ext - CMP_BITS'(1);
			end
			OP_REM_AT: begin
				is_rem  = 1'b1;
				tgt_pos = CMP_BITS'(req.position);
			end
			default: begin
				// unused codes: plain ok, nothing moves
			end
		endcase
	end

	// status check and the command broadcast to the cells
	always_comb begin
		st_dec    = ST_OK;
		cmd.kind  = CMD_HOLD;
		cmd.pos   = tgt_pos;
		cmd.value = req.value;
		if (is_ins) begin
			if (full) begin
				st_dec = ST_FULL;
			end else if (tgt_pos > cnt_ext) begin
				st_dec = ST_RANGE;
			end else if (req_fire) begin
				cmd.kind = CMD_INS;
			end
		end else if (is_rem) begin
			if (empty) begin
				st_dec = ST_EMPTY;
			end else if (tgt_pos >= cnt_ext) begin
				st_dec = ST_RANGE;
			end else if (req_fire) begin
				cmd.kind = CMD_REM;
			end
		end
	end

	// row of slot cells, each shifting with its neighbors
	for (genvar i = 0; i < NUM_GROUPS * GROUP_SIZE; i++) begin : g_slot
		if (i < CAPACITY) begin : g_cell
			word_t left_w;
			word_t right_w;

			if (i == 0) begin : g_head
				// head cell never takes from the left
				assign left_w = '0;
			end else begin : g_mid_l
				assign left_w = cell_word[i-1];
			end

			if (i == CAPACITY - 1) begin : g_last
				// last cell keeps its word on a shift down
				assign right_w = cell_word[i];
			end else begin : g_mid_r
				assign right_w = cell_word[i+1];
			end

			sle_cell u_cell (
				.clk        (clk),
				.cmd        (cmd),
				.index      (CMP_BITS'(i)),
				.left_word  (left_w),
				.right_word (right_w),
				.word       (cell_word[i]),
				.tap        (taps_all[i / GROUP_SIZE][i % GROUP_SIZE])
			);
		end else begin : g_pad
			// padding of the last group
			assign taps_all[i / GROUP_SIZE][i % GROUP_SIZE] = '0;
		end
	end

	// first gather level, registered per group
	for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_grp
		sle_group u_group (
			.clk  (clk),
			.load (v_s1),
			.taps (taps_all[g]),
			.acc  (grp_acc[g])
		);
	end

	// second gather level feeds the output register
	always_comb begin
		gather = '0;
		for (int g = 0; g < NUM_GROUPS; g++) begin
			gather = gather | grp_acc[g];
		end
	end

	// control: count, stage valids, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.kind == CMD_INS) begin
				count_q <= count_q + CNT_BITS'(1);
			end else if (cmd.kind == CMD_REM) begin
				count_q <= count_q - CNT_BITS'(1);
			end
			v_s1 <= req_fire;
			if (v_s1) begin
				v_s2 <= 1'b1;
			end else if (out_load) begin
				v_s2 <= 1'b0;
			end
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload follows the item through the stages
	always_ff @(posedge clk) begin
		if (req_fire) begin
			st_s1  <= st_dec;
			cnt_s1 <= (cmd.kind == CMD_INS) ? count_q + CNT_BITS'(1) :
			          (cmd.kind == CMD_REM) ? count_q - CNT_BITS'(1) : count_q;
		end
		if (v_s1) begin
			st_s2  <= st_s1;
			cnt_s2 <= cnt_s1;
		end
		if (out_load) begin
			removed_q     <= gather;
			status_q      <= st_s2;
			entry_count_q <= cnt_s2;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.removed_word = removed_q;
	assign rsp.status       = status_q;
	assign rsp.entry_count  = COUNT_BITS'(entry_count_q);

	// list never grows past its capacity
	`SLE_ASSERT_IMPLY(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_BITS'(CAPACITY))
	// a successful insert adds exactly one entry
	`SLE_ASSERT_NEXT(a_ins_grows, clk, arst_n, req_fire && cmd.kind == CMD_INS, count_q == $past(count_q) + CNT_BITS'(1))
	// a failed operation leaves the count alone
	`SLE_ASSERT_NEXT(a_fail_keeps, clk, arst_n, req_fire && st_dec != ST_OK, count_q == $past(count_q))
	// at most one item between decode and the output register
	`SLE_ASSERT_IMPLY(a_one_in_flight, clk, arst_n, 1'b1, $onehot0({v_s1, v_s2}))
	// a failed operation gathers no word
	`SLE_ASSERT_NEXT(a_fail_zero, clk, arst_n, out_load && st_s2 != ST_OK, removed_q == '0)
endmodule
